// File: sv/mau_pkg.sv
// ----------------------------------------------------------------------------
// Modular arithmetic unit package
// Shared types, constants and modular helper functions.
// ----------------------------------------------------------------------------
package mau_pkg;

    localparam int WORD_BITS = 32;
    localparam int CNT_BITS  = $clog2(WORD_BITS);

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [WORD_BITS:0]   wide_t;
    typedef logic [CNT_BITS-1:0]  cnt_t;

    typedef enum logic [1:0] {
        FUNC_ADD = 2'd0,
        FUNC_SUB = 2'd1,
        FUNC_MUL = 2'd2,
        FUNC_DIV = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_MUL,
        ST_EU_TEST,
        ST_EU_DIV,
        ST_EU_UPD,
        ST_FINISH
    } state_t;

    typedef struct packed {
        func_t func;
        word_t left_operand;
        word_t right_operand;
    } in_req_t;

    typedef struct packed {
        word_t result_value;
        logic  no_inverse;
    } out_req_t;

    localparam cnt_t CNT_LAST = CNT_BITS'(WORD_BITS - 1);

    // a, b < n
    function automatic word_t mod_add(word_t a, word_t b, word_t n);
        wide_t s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, n})
            s = s - {1'b0, n};
        return s[WORD_BITS-1:0];
    endfunction

    function automatic word_t mod_sub(word_t a, word_t b, word_t n);
        word_t d;
        if (a >= b)
            d = a - b;
        else
            d = (n - b) + a;
        return d;
    endfunction

    // r < n: (2r + b) mod n
    function automatic word_t shift_in(word_t r, logic b, word_t n);
        wide_t d;
        d = {r, b};
        if (d >= {1'b0, n})
            d = d - {1'b0, n};
        return d[WORD_BITS-1:0];
    endfunction

    // one Horner step of a modular product: (2acc + b*a) mod n
    function automatic word_t horner(word_t acc, logic b, word_t a, word_t n);
        word_t d;
        d = shift_in(acc, 1'b0, n);
        if (b)
            d = mod_add(d, a, n);
        return d;
    endfunction

endpackage

// File: sv/modular_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// Modular arithmetic unit
// Add, subtract, multiply and divide modulo a configured modulus.
// ----------------------------------------------------------------------------
// Usage:
//   cfg channel: cfg_valid/cfg_ready with cfg_data = modulus (0 acts as 1).
//     Write only while idle. cfg_ready is always high.
//   in channel: in_valid/in_stall with in_data {func, left, right}.
//   out channel: out_valid/out_stall with out_data {result_value, no_inverse}.
// One request at a time. Both operands are reduced bit-serially, together;
// add/sub then finish with one modular step, multiply with a bit-serial product.
// Divide runs extended Euclid, each step a bit-serial long division with
// a merged quotient*coefficient product, for up to about 1.44*WORD_BITS
// steps, then a bit-serial product when an inverse exists.
// The result register lets the next request enter while a result waits;
// a new result is held back while out_stall keeps the previous one.
// Reset: modulus 1, idle, no result pending.
// ----------------------------------------------------------------------------
module modular_arithmetic_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  mau_pkg::word_t      cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  mau_pkg::in_req_t    in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output mau_pkg::out_req_t   out_data
);

    localparam int W = mau_pkg::WORD_BITS;

    mau_pkg::state_t  state_reg, state_next;
    mau_pkg::word_t   modulus_reg, modulus_next;
    mau_pkg::func_t   func_reg, func_next;
    mau_pkg::cnt_t    cnt_reg, cnt_next;
    mau_pkg::word_t   bits_reg, bits_next;
    mau_pkg::word_t   ysh_reg, ysh_next;
    mau_pkg::word_t   x_reg, x_next;
    mau_pkg::word_t   y_reg, y_next;
    mau_pkg::word_t   a_reg, a_next;
    mau_pkg::word_t   acc_reg, acc_next;
    mau_pkg::word_t   rem_reg, rem_next;
    mau_pkg::word_t   r0_reg, r0_next;
    mau_pkg::word_t   r1_reg, r1_next;
    mau_pkg::word_t   t0_reg, t0_next;
    mau_pkg::word_t   t1_reg, t1_next;
    logic             flag_reg, flag_next;
    logic             out_valid_reg, out_valid_next;
    mau_pkg::out_req_t out_reg, out_next;

    mau_pkg::word_t   n_eff;
    mau_pkg::word_t   x_red, y_red;
    mau_pkg::wide_t   rem2;
    logic             q_bit;
    logic             accept;
    logic             last;
    logic             out_free;

    assign n_eff    = (modulus_reg == '0) ? mau_pkg::word_t'(1) : modulus_reg;
    assign accept   = in_valid && !in_stall;
    assign last     = (cnt_reg == '0);
    assign out_free = !out_valid_reg || !out_stall;
    assign x_red    = mau_pkg::shift_in(x_reg, bits_reg[W-1], n_eff);
    assign y_red    = mau_pkg::shift_in(y_reg, ysh_reg[W-1], n_eff);
    assign rem2     = {rem_reg, bits_reg[W-1]};
    assign q_bit    = (rem2 >= {1'b0, r1_reg});

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != mau_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mau_pkg::ST_IDLE:
                if (accept)
                    state_next = mau_pkg::ST_REDUCE;
            mau_pkg::ST_REDUCE:
                if (last)
                begin
                    case (func_reg)
                        mau_pkg::FUNC_MUL: state_next = mau_pkg::ST_MUL;
                        mau_pkg::FUNC_DIV: state_next = mau_pkg::ST_EU_TEST;
                        default:           state_next = mau_pkg::ST_FINISH;
                    endcase
                end
            mau_pkg::ST_MUL:
                if (last)
                    state_next = mau_pkg::ST_FINISH;
            mau_pkg::ST_EU_TEST:
                if (r1_reg != '0)
                    state_next = mau_pkg::ST_EU_DIV;
                else if (r0_reg == mau_pkg::word_t'(1))
                    state_next = mau_pkg::ST_MUL;
                else
                    state_next = mau_pkg::ST_FINISH;
            mau_pkg::ST_EU_DIV:
                if (last)
                    state_next = mau_pkg::ST_EU_UPD;
            mau_pkg::ST_EU_UPD:
                state_next = mau_pkg::ST_EU_TEST;
            mau_pkg::ST_FINISH:
                if (out_free)
                    state_next = mau_pkg::ST_IDLE;
            default:
                state_next = mau_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        modulus_next   = modulus_reg;
        func_next      = func_reg;
        cnt_next       = cnt_reg;
        bits_next      = bits_reg;
        ysh_next       = ysh_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        a_next         = a_reg;
        acc_next       = acc_reg;
        rem_next       = rem_reg;
        r0_next        = r0_reg;
        r1_next        = r1_reg;
        t0_next        = t0_reg;
        t1_next        = t1_reg;
        flag_next      = flag_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;

        if (cfg_valid)
            modulus_next = cfg_data;

        case (state_reg)
            mau_pkg::ST_IDLE:
                if (accept)
                begin
                    func_next = in_data.func;
                    bits_next = in_data.left_operand;
                    ysh_next  = in_data.right_operand;
                    x_next    = '0;
                    y_next    = '0;
                    flag_next = 1'b0;
                    cnt_next  = mau_pkg::CNT_LAST;
                end
            mau_pkg::ST_REDUCE:
            begin
                x_next    = x_red;
                y_next    = y_red;
                bits_next = bits_reg << 1;
                ysh_next  = ysh_reg << 1;
                cnt_next  = cnt_reg - 1'b1;
                if (last)
                begin
                    cnt_next = mau_pkg::CNT_LAST;
                    acc_next = '0;
                    case (func_reg)
                        mau_pkg::FUNC_ADD: acc_next = mau_pkg::mod_add(x_red, y_red, n_eff);
                        mau_pkg::FUNC_SUB: acc_next = mau_pkg::mod_sub(x_red, y_red, n_eff);
                        mau_pkg::FUNC_MUL:
                        begin
                            a_next    = x_red;
                            bits_next = y_red;
                        end
                        default:
                        begin
                            r0_next = n_eff;
                            r1_next = y_red;
                            t0_next = '0;
                            t1_next = (n_eff > mau_pkg::word_t'(1)) ?
                                      mau_pkg::word_t'(1) : '0;
                        end
                    endcase
                end
            end
            mau_pkg::ST_MUL:
            begin
                acc_next  = mau_pkg::horner(acc_reg, bits_reg[W-1], a_reg, n_eff);
                bits_next = bits_reg << 1;
                cnt_next  = cnt_reg - 1'b1;
            end
            mau_pkg::ST_EU_TEST:
            begin
                acc_next = '0;
                cnt_next = mau_pkg::CNT_LAST;
                if (r1_reg != '0)
                begin
                    bits_next = r0_reg;
                    rem_next  = '0;
                end
                else if (r0_reg == mau_pkg::word_t'(1))
                begin
                    a_next    = x_reg;
                    bits_next = t0_reg;
                end
                else
                    flag_next = 1'b1;
            end
            mau_pkg::ST_EU_DIV:
            begin
                rem_next  = q_bit ? W'(rem2 - {1'b0, r1_reg}) : W'(rem2);
                acc_next  = mau_pkg::horner(acc_reg, q_bit, t1_reg, n_eff);
                bits_next = bits_reg << 1;
                cnt_next  = cnt_reg - 1'b1;
            end
            mau_pkg::ST_EU_UPD:
            begin
                r0_next = r1_reg;
                r1_next = rem_reg;
                t0_next = t1_reg;
                t1_next = mau_pkg::mod_sub(t0_reg, acc_reg, n_eff);
            end
            mau_pkg::ST_FINISH:
                if (out_free)
                begin
                    out_next.result_value = acc_reg;
                    out_next.no_inverse   = flag_reg;
                    out_valid_next        = 1'b1;
                end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mau_pkg::ST_IDLE;
            modulus_reg   <= mau_pkg::word_t'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            modulus_reg   <= modulus_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg <= func_next;
        cnt_reg  <= cnt_next;
        bits_reg <= bits_next;
        ysh_reg  <= ysh_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        a_reg    <= a_next;
        acc_reg  <= acc_next;
        rem_reg  <= rem_next;
        r0_reg   <= r0_next;
        r1_reg   <= r1_next;
        t0_reg   <= t0_next;
        t1_reg   <= t1_next;
        flag_reg <= flag_next;
        out_reg  <= out_next;
    end

endmodule

// File: sv/mau_checker.sv
// ----------------------------------------------------------------------------
// Modular arithmetic unit checker
// Port-level assertions, bound to modular_arithmetic_unit.
// ----------------------------------------------------------------------------
module mau_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input mau_pkg::out_req_t   out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_data))
        else $error("stalled result changed");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second request taken while busy");

    a_noinv_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.no_inverse |-> out_data.result_value == '0)
        else $error("no-inverse result not zero");

endmodule

bind modular_arithmetic_unit mau_checker u_mau_checker (.*);

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// Modular arithmetic unit testbench
// Drives add, subtract, multiply and divide requests under several moduli,
// predicts each result and compares it with what the unit returns.
// ----------------------------------------------------------------------------
module testbench;

    localparam int IDLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 2000;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    mau_pkg::word_t     cfg_data;
    logic               in_valid;
    logic               in_stall;
    mau_pkg::in_req_t   in_data;
    logic               out_valid;
    logic               out_stall;
    mau_pkg::out_req_t  out_data;

    mau_pkg::word_t     modulus_q;
    mau_pkg::out_req_t  expected_results[$];
    int                 error_count;
    int                 idle_cycles;
    int                 hold_off;
    int                 burst_left;

    modular_arithmetic_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [63:0] mulmod(logic [63:0] a, logic [63:0] b, logic [63:0] n);
        logic [127:0] p;
        p = a * b;
        return 64'(p % n);
    endfunction

    function automatic mau_pkg::out_req_t predict_result(mau_pkg::in_req_t req,
                                                         mau_pkg::word_t modulus);
        logic [63:0] n;
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] r0;
        logic [63:0] r1;
        logic [63:0] r2;
        logic [63:0] t0;
        logic [63:0] t1;
        logic [63:0] t2;
        logic [63:0] q;
        logic [63:0] qt;
        mau_pkg::out_req_t res;
        n = (modulus == '0) ? 64'd1 : 64'(modulus);
        x = 64'(req.left_operand) % n;
        y = 64'(req.right_operand) % n;
        res.no_inverse = 1'b0;
        res.result_value = '0;
        case (req.func)
            mau_pkg::FUNC_ADD: res.result_value = mau_pkg::word_t'((x + y) % n);
            mau_pkg::FUNC_SUB: res.result_value = mau_pkg::word_t'((x + n - y) % n);
            mau_pkg::FUNC_MUL: res.result_value = mau_pkg::word_t'(mulmod(x, y, n));
            default:
            begin
                r0 = n;
                r1 = y;
                t0 = '0;
                t1 = (n > 64'd1) ? 64'd1 : 64'd0;
                for (int s = 0; s < 2 * mau_pkg::WORD_BITS + 4 && r1 != '0; s++)
                begin
                    q = r0 / r1;
                    r2 = r0 - q * r1;
                    qt = mulmod(q % n, t1, n);
                    t2 = (t0 >= qt) ? t0 - qt : (n - qt) + t0;
                    r0 = r1;
                    r1 = r2;
                    t0 = t1;
                    t1 = t2;
                end
                if (r0 == 64'd1)
                    res.result_value = mau_pkg::word_t'(mulmod(x, t0 % n, n));
                else
                    res.no_inverse = 1'b1;
            end
        endcase
        return res;
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch: %s", what);
        error_count++;
    endtask

    task automatic send_request(mau_pkg::func_t f, mau_pkg::word_t x, mau_pkg::word_t y);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= '{func: f, left_operand: x, right_operand: y};
        do
            @(posedge clk);
        while (in_stall);
        expected_results.push_back(predict_result(
            '{func: f, left_operand: x, right_operand: y}, modulus_q));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        burst_left = 0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_modulus(mau_pkg::word_t value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        modulus_q = value;
    endtask

    function automatic mau_pkg::word_t random_word();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return mau_pkg::word_t'($urandom_range(0, 20));
            3: return modulus_q - mau_pkg::word_t'($urandom_range(0, 2));
            default: return mau_pkg::word_t'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        mau_pkg::word_t mods[4] = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd97};
        foreach (mods[m])
        begin
            write_modulus(mods[m]);
            send_request(mau_pkg::FUNC_ADD, '1, '1);
            send_request(mau_pkg::FUNC_SUB, '0, '1);
            send_request(mau_pkg::FUNC_MUL, '1, 32'hFFFF_FFFE);
            send_request(mau_pkg::FUNC_DIV, 32'd5, '0);
            send_request(mau_pkg::FUNC_DIV, '1, 32'd3);
            send_request(mau_pkg::FUNC_DIV, 32'd7, 32'd194);
        end
    endtask

    task automatic test_random();
        mau_pkg::word_t mods[6] = '{32'd2, 32'd12, 32'd65536, 32'hFFFF_FFFB,
                                    32'h8000_0000, 32'd1000};
        for (int p = 0; p < 8; p++)
        begin
            if (p < 6)
                write_modulus(mods[p]);
            else
                write_modulus(mau_pkg::word_t'($urandom));
            repeat (95)
                send_request(mau_pkg::func_t'($urandom_range(0, 3)), random_word(),
                             random_word());
        end
    endtask

    task automatic test_backpressure();
        hold_off = 3000;
        repeat (6)
            send_request(mau_pkg::func_t'($urandom_range(0, 3)),
                         mau_pkg::word_t'($urandom), mau_pkg::word_t'($urandom));
        wait_drained();
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_off > 0)
            begin
                hold_off <= hold_off - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(0, 3) == 0);
            end
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("result with nothing expected");
                end
                else
                begin
                    if (out_data.result_value !== expected_results[0].result_value)
                        report_mismatch($sformatf("result_value %h expected %h",
                            out_data.result_value, expected_results[0].result_value));
                    if (out_data.no_inverse !== expected_results[0].no_inverse)
                        report_mismatch($sformatf("no_inverse %b expected %b",
                            out_data.no_inverse, expected_results[0].no_inverse));
                    void'(expected_results.pop_front());
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        error_count = 0;
        idle_cycles = 0;
        hold_off = 0;
        burst_left = 0;
        modulus_q = 32'd1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_random();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: sim.f
sv/mau_pkg.sv
sv/modular_arithmetic_unit.sv
sv/mau_checker.sv
bench/testbench.sv
